// File: src/spma_pkg.sv
// ----------------------------------------------------------------------------
// spma_pkg
// Types, codes and helpers shared by the sparse polynomial merge-add block.
// ----------------------------------------------------------------------------
package spma_pkg;

   localparam int TERM_DEPTH_DEF  = 32;
   localparam int COEF_W          = 32;
   localparam int EXP_W           = 16;
   localparam int FUNC_W          = 2;
   localparam int CMD_QUEUE_DEPTH = 2;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_MERGE       = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_IGNORED     = 2'd3;

   localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_LOAD_FIRST  = 2'd0,
      OP_LOAD_SECOND = 2'd1,
      OP_MERGE       = 2'd2
   } op_type;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [COEF_W-1:0] coef;
      logic [EXP_W-1:0]         exponent;
   } req_payload_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] sum_coef;
      logic [EXP_W-1:0]         sum_exponent;
      logic                     last;
      logic                     empty_res;
      logic                     overflow;
   } rsp_payload_type;

   typedef struct packed {
      op_type                   op;
      logic signed [COEF_W-1:0] coef;
      logic [EXP_W-1:0]         exponent;
   } cmd_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic [EXP_W-1:0]         exponent;
   } term_type;

   function automatic logic signed [COEF_W-1:0] sat_add(
      input logic signed [COEF_W-1:0] a,
      input logic signed [COEF_W-1:0] b
   );
      logic signed [COEF_W:0] s;
      logic signed [COEF_W-1:0] r;
      s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
      if (s[COEF_W] != s[COEF_W-1]) begin
         r = s[COEF_W] ? COEF_MIN : COEF_MAX;
      end else begin
         r = s[COEF_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: src/spma_chan_if.sv
// ----------------------------------------------------------------------------
// spma_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface spma_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/spma_front.sv
// ----------------------------------------------------------------------------
// spma_front
// Accepts request transactions, decodes the function code and queues
// commands for the back end. Reserved codes are dropped here.
// ----------------------------------------------------------------------------
module spma_front (
   input  logic             clock,
   input  logic             reset,
   spma_chan_if.sink        req_if,
   output spma_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_ready
);
   import spma_pkg::*;

   localparam int QPTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type           queue_ff [CMD_QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   cmd_type decoded;
   logic    keep;
   logic    accept;
   logic    push;
   logic    pop;

   always_comb begin
      decoded.coef     = req_if.payload.coef;
      decoded.exponent = req_if.payload.exponent;
      decoded.op       = OP_MERGE;
      keep             = 1'b0;
      unique case (req_if.payload.func)
         FUNC_LOAD_FIRST: begin
            decoded.op = OP_LOAD_FIRST;
            keep       = 1'b1;
         end
         FUNC_LOAD_SECOND: begin
            decoded.op = OP_LOAD_SECOND;
            keep       = 1'b1;
         end
         FUNC_MERGE: begin
            decoded.op = OP_MERGE;
            keep       = 1'b1;
         end
         FUNC_IGNORED: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_if.ready = (count_ff != QCNT_W'(CMD_QUEUE_DEPTH));
   assign accept       = req_if.valid && req_if.ready;
   assign push         = accept && keep;
   assign cmd_valid    = (count_ff != '0);
   assign pop          = cmd_valid && cmd_ready;
   assign cmd          = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + QCNT_W'(1));
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - QCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(CMD_QUEUE_DEPTH))
      else $error("command queue count out of range");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == QCNT_W'($past(count_ff) + QCNT_W'(1)))
      else $error("command queue did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == QCNT_W'($past(count_ff) - QCNT_W'(1)))
      else $error("command queue did not shrink on pop");

endmodule

// File: src/spma_back.sv
// ----------------------------------------------------------------------------
// spma_back
// Term stores, counts and the merge engine. Loads fill the stores; a merge
// walks both stores and emits one result term per cycle unless output stalls.
// ----------------------------------------------------------------------------
module spma_back #(
   parameter int TERM_DEPTH = spma_pkg::TERM_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  spma_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   spma_chan_if.source       rsp_if
);
   import spma_pkg::*;

   localparam int CNT_W = $clog2(TERM_DEPTH + 1);
   localparam int IDX_W = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EMPTY = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

   term_type first_mem  [TERM_DEPTH];
   term_type second_mem [TERM_DEPTH];

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] first_count_ff, first_count_in;
   logic [CNT_W-1:0] second_count_ff, second_count_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   term_type         head1_ff, head2_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic             cmd_take;
   logic             out_free;
   logic             more1, more2;
   logic             take1, take2;
   logic             step;
   logic             last_term;
   logic             wr1, wr2;
   logic [IDX_W-1:0] rd1_addr, rd2_addr;
   term_type         load_term;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign cmd_take  = cmd_valid && cmd_ready;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign more1     = (i_ff < first_count_ff);
   assign more2     = (j_ff < second_count_ff);
   assign take1     = !more2 || (more1 && (head1_ff.exponent > head2_ff.exponent));
   assign take2     = !more1 || (more2 && (head2_ff.exponent > head1_ff.exponent));
   assign step      = (state_ff == ST_RUN) && out_free;
   assign last_term = (i_in >= first_count_ff) && (j_in >= second_count_ff);

   assign load_term.coef     = cmd.coef;
   assign load_term.exponent = cmd.exponent;

   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      wr1             = 1'b0;
      wr2             = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in     = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_take) begin
               unique case (cmd.op)
                  OP_LOAD_FIRST: begin
                     if (first_count_ff < CNT_W'(TERM_DEPTH)) begin
                        wr1            = 1'b1;
                        first_count_in = CNT_W'(first_count_ff + CNT_W'(1));
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_LOAD_SECOND: begin
                     if (second_count_ff < CNT_W'(TERM_DEPTH)) begin
                        wr2             = 1'b1;
                        second_count_in = CNT_W'(second_count_ff + CNT_W'(1));
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_MERGE: begin
                     i_in = '0;
                     j_in = '0;
                     if (first_count_ff == '0 && second_count_ff == '0) begin
                        state_in = ST_EMPTY;
                     end else begin
                        state_in = ST_RUN;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sum_coef     = '0;
               rsp_data_in.sum_exponent = '0;
               rsp_data_in.last         = 1'b1;
               rsp_data_in.empty_res    = 1'b1;
               rsp_data_in.overflow     = dropped_ff;
               dropped_in               = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (step) begin
               priority if (take1) begin
                  i_in                     = CNT_W'(i_ff + CNT_W'(1));
                  rsp_data_in.sum_coef     = head1_ff.coef;
                  rsp_data_in.sum_exponent = head1_ff.exponent;
               end else if (take2) begin
                  j_in                     = CNT_W'(j_ff + CNT_W'(1));
                  rsp_data_in.sum_coef     = head2_ff.coef;
                  rsp_data_in.sum_exponent = head2_ff.exponent;
               end else begin
                  i_in                     = CNT_W'(i_ff + CNT_W'(1));
                  j_in                     = CNT_W'(j_ff + CNT_W'(1));
                  rsp_data_in.sum_coef     = sat_add(head1_ff.coef, head2_ff.coef);
                  rsp_data_in.sum_exponent = head2_ff.exponent;
               end
               rsp_valid_in          = 1'b1;
               rsp_data_in.last      = last_term;
               rsp_data_in.empty_res = 1'b0;
               rsp_data_in.overflow  = dropped_ff;
               if (last_term) begin
                  first_count_in  = '0;
                  second_count_in = '0;
                  dropped_in      = 1'b0;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd1_addr = (i_in < CNT_W'(TERM_DEPTH)) ? i_in[IDX_W-1:0] : '0;
   assign rd2_addr = (j_in < CNT_W'(TERM_DEPTH)) ? j_in[IDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (wr1) begin
         first_mem[first_count_ff[IDX_W-1:0]] <= load_term;
      end
      if (wr2) begin
         second_mem[second_count_ff[IDX_W-1:0]] <= load_term;
      end
   end

   always_ff @(posedge clock) begin
      head1_ff <= first_mem[rd1_addr];
      head2_ff <= second_mem[rd2_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         i_ff            <= '0;
         j_ff            <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      first_count_ff <= CNT_W'(TERM_DEPTH) && second_count_ff <= CNT_W'(TERM_DEPTH))
      else $error("term count beyond store depth");

   a_run_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> (more1 || more2) &&
         i_ff <= first_count_ff && j_ff <= second_count_ff)
      else $error("merge running with no terms left");

   a_merge_clears: assert property (@(posedge clock) disable iff (reset)
      (step && last_term) |=> state_ff == ST_IDLE && first_count_ff == '0 &&
         second_count_ff == '0 && !dropped_ff)
      else $error("stores not cleared after merge");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.empty_res) |-> rsp_data_ff.last)
      else $error("empty marker without last");

endmodule

// File: src/sparse_poly_merge_add_top.sv
// Timing: a load lands in its store when the back end takes it from the command queue;
// a merge moves the back end into its run state as it leaves the queue, and its first
// term is then registered onto the output; the empty marker likewise.
// Throughput: one load per cycle; a merge streams one term per cycle while the output
// is free, paced by the registered store reads, and input stalls once the queue fills.
// Reset: synchronous; clears counts, drop flag, queue and output valid, not stores.
// ----------------------------------------------------------------------------
// sparse_poly_merge_add_top
// Sparse polynomial adder: two term stores loaded in descending exponent
// order, merged into one saturated 16.16 result stream on command.
// ----------------------------------------------------------------------------
module sparse_poly_merge_add_top #(
   parameter int TERM_DEPTH = spma_pkg::TERM_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   spma_chan_if.sink   req_if,
   spma_chan_if.source rsp_if
);
   import spma_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   spma_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   spma_back #(
      .TERM_DEPTH (TERM_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .rsp_if    (rsp_if)
   );

endmodule

// File: sim/sparse_poly_merge_add_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_poly_merge_add_top_tb
// Streams term loads and merge commands into the sparse polynomial adder and
// checks every emitted term against a cycle-free predictor of the two term
// stores. The run covers saturating sums, zero sums, leftover terms, unsorted
// input, full stores and empty merges, with random idling on both channels
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module sparse_poly_merge_add_top_tb;
   import spma_pkg::*;

   localparam int          TERM_DEPTH  = TERM_DEPTH_DEF;
   localparam int          HOLD_CYCLES = 400;
   localparam int          TAIL_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;

   spma_chan_if #(.payload_type(req_payload_type)) req_chan ();
   spma_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   sparse_poly_merge_add_top #(
      .TERM_DEPTH (TERM_DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   req_payload_type pending_items[$];
   rsp_payload_type expected_terms[$];

   term_type    first_terms[TERM_DEPTH];
   term_type    second_terms[TERM_DEPTH];
   int unsigned first_len;
   int unsigned second_len;
   bit          load_dropped;

   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   bit          hold_armed;
   int unsigned hold_count;
   int unsigned queued_count;
   int unsigned error_count;
   int unsigned cycle_count;

   always #6 clock = ~clock;

   function automatic logic signed [COEF_W-1:0] clamp_coef_sum(
      input logic signed [COEF_W-1:0] a,
      input logic signed [COEF_W-1:0] b
   );
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'(COEF_MAX)) begin
         return COEF_MAX;
      end
      if (s < longint'(COEF_MIN)) begin
         return COEF_MIN;
      end
      return s[COEF_W-1:0];
   endfunction

   function automatic void push_term(
      input logic signed [COEF_W-1:0] coef,
      input logic [EXP_W-1:0]         exponent,
      input logic                     last,
      input logic                     empty_res
   );
      rsp_payload_type r;
      r.sum_coef     = coef;
      r.sum_exponent = exponent;
      r.last         = last;
      r.empty_res    = empty_res;
      r.overflow     = load_dropped;
      expected_terms.push_back(r);
   endfunction

   function automatic void predict_sum(input req_payload_type item);
      int unsigned i;
      int unsigned j;
      bit          take_first;
      bit          take_second;
      logic signed [COEF_W-1:0] c;
      logic [EXP_W-1:0]         e;
      case (item.func)
         FUNC_LOAD_FIRST: begin
            if (first_len < TERM_DEPTH) begin
               first_terms[first_len].coef     = item.coef;
               first_terms[first_len].exponent = item.exponent;
               first_len++;
            end else begin
               load_dropped = 1'b1;
            end
         end
         FUNC_LOAD_SECOND: begin
            if (second_len < TERM_DEPTH) begin
               second_terms[second_len].coef     = item.coef;
               second_terms[second_len].exponent = item.exponent;
               second_len++;
            end else begin
               load_dropped = 1'b1;
            end
         end
         FUNC_MERGE: begin
            if (first_len == 0 && second_len == 0) begin
               push_term('0, '0, 1'b1, 1'b1);
            end else begin
               i = 0;
               j = 0;
               while (i < first_len || j < second_len) begin
                  take_first = (j >= second_len) ||
                     (i < first_len && first_terms[i].exponent > second_terms[j].exponent);
                  take_second = (i >= first_len) ||
                     (j < second_len && second_terms[j].exponent > first_terms[i].exponent);
                  if (take_first) begin
                     c = first_terms[i].coef;
                     e = first_terms[i].exponent;
                     i++;
                  end else if (take_second) begin
                     c = second_terms[j].coef;
                     e = second_terms[j].exponent;
                     j++;
                  end else begin
                     c = clamp_coef_sum(first_terms[i].coef, second_terms[j].coef);
                     e = second_terms[j].exponent;
                     i++;
                     j++;
                  end
                  push_term(c, e, (i >= first_len && j >= second_len), 1'b0);
               end
            end
            first_len    = 0;
            second_len   = 0;
            load_dropped = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_sum(req_chan.payload);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_chan.payload <= pending_items.pop_front();
               req_chan.valid   <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver ready, with one long hold-off once armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_armed && hold_count < HOLD_CYCLES) begin
         rsp_chan.ready <= 1'b0;
         hold_count++;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_terms.size() == 0) begin
            $error("unexpected transaction: sum_coef %0d sum_exponent %0d",
                   rsp_chan.payload.sum_coef, rsp_chan.payload.sum_exponent);
            error_count++;
         end else begin
            want = expected_terms.pop_front();
            if (rsp_chan.payload.sum_coef !== want.sum_coef) begin
               $error("sum_coef: expected %0d, got %0d",
                      want.sum_coef, rsp_chan.payload.sum_coef);
               error_count++;
            end
            if (rsp_chan.payload.sum_exponent !== want.sum_exponent) begin
               $error("sum_exponent: expected %0d, got %0d",
                      want.sum_exponent, rsp_chan.payload.sum_exponent);
               error_count++;
            end
            if (rsp_chan.payload.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_chan.payload.last);
               error_count++;
            end
            if (rsp_chan.payload.empty_res !== want.empty_res) begin
               $error("empty_res: expected %0b, got %0b",
                      want.empty_res, rsp_chan.payload.empty_res);
               error_count++;
            end
            if (rsp_chan.payload.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b",
                      want.overflow, rsp_chan.payload.overflow);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sparse_poly_merge_add_top_tb failed");
         $finish;
      end
   end

   task automatic queue_item(
      input logic [FUNC_W-1:0]        func,
      input logic signed [COEF_W-1:0] coef,
      input logic [EXP_W-1:0]         exponent
   );
      req_payload_type item;
      item.func     = func;
      item.coef     = coef;
      item.exponent = exponent;
      pending_items.push_back(item);
      if (func != FUNC_IGNORED) begin
         queued_count++;
      end
   endtask

   function automatic logic signed [COEF_W-1:0] rand_coef();
      case ($urandom_range(5))
         0:       return COEF_MAX - COEF_W'($urandom_range(3));
         1:       return COEF_MIN + COEF_W'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   function automatic void make_exponents(
      output logic [EXP_W-1:0] list[$],
      input  int unsigned      n,
      input  logic [EXP_W-1:0] top,
      input  bit               sorted
   );
      int unsigned cur;
      int unsigned step;
      list = {};
      cur  = top;
      repeat (n) begin
         if (sorted) begin
            list.push_back(EXP_W'(cur));
            step = $urandom_range(1, 3);
            if (cur < step) begin
               break;
            end
            cur -= step;
         end else begin
            list.push_back(EXP_W'($urandom_range(40)));
         end
      end
   endfunction

   task automatic queue_poly_pair();
      int unsigned      mode;
      int unsigned      n_first;
      int unsigned      n_second;
      logic [EXP_W-1:0] top;
      logic [EXP_W-1:0] exps_first[$];
      logic [EXP_W-1:0] exps_second[$];
      bit               sorted;
      mode   = $urandom_range(99);
      sorted = 1'b1;
      case ($urandom_range(3))
         0:       top = 16'hFFFF;
         1:       top = EXP_W'($urandom_range(4, 40));
         default: top = EXP_W'($urandom);
      endcase
      if (mode < 6) begin
         repeat ($urandom_range(1, 3)) begin
            queue_item(FUNC_IGNORED, rand_coef(), EXP_W'($urandom));
         end
         if ($urandom_range(1)) begin
            queue_item(FUNC_MERGE, rand_coef(), EXP_W'($urandom));
         end
         return;
      end else if (mode < 10) begin
         n_first  = $urandom_range(28, 35);
         n_second = $urandom_range(28, 35);
         top      = EXP_W'($urandom_range(16'h0200, 16'hFFFF));
      end else if (mode < 16) begin
         n_first  = $urandom_range(1, 6);
         n_second = $urandom_range(1, 6);
         sorted   = 1'b0;
      end else begin
         n_first  = $urandom_range(0, 7);
         n_second = $urandom_range(0, 7);
      end
      make_exponents(exps_first, n_first, top, sorted);
      make_exponents(exps_second, n_second, top, sorted);
      while (exps_first.size() != 0 || exps_second.size() != 0) begin
         if ($urandom_range(99) < 3) begin
            queue_item(FUNC_IGNORED, rand_coef(), EXP_W'($urandom));
         end
         if (exps_second.size() == 0 || (exps_first.size() != 0 && $urandom_range(1))) begin
            queue_item(FUNC_LOAD_FIRST, rand_coef(), exps_first.pop_front());
         end else begin
            queue_item(FUNC_LOAD_SECOND, rand_coef(), exps_second.pop_front());
         end
      end
      queue_item(FUNC_MERGE, rand_coef(), EXP_W'($urandom));
   endtask

   task automatic queue_directed();
      queue_item(FUNC_MERGE, '0, '0);
      queue_item(FUNC_LOAD_FIRST, COEF_MAX, 16'hFFFF);
      queue_item(FUNC_LOAD_SECOND, 32'sd1, 16'hFFFF);
      queue_item(FUNC_LOAD_FIRST, COEF_MIN, 16'h8000);
      queue_item(FUNC_LOAD_SECOND, -32'sd1, 16'h8000);
      queue_item(FUNC_LOAD_FIRST, 32'sh0001_0000, 16'd100);
      queue_item(FUNC_LOAD_SECOND, -32'sh0001_0000, 16'd100);
      queue_item(FUNC_LOAD_FIRST, 32'sd5, 16'd50);
      queue_item(FUNC_LOAD_SECOND, 32'sd7, 16'd60);
      queue_item(FUNC_LOAD_SECOND, 32'sd9, 16'd0);
      queue_item(FUNC_IGNORED, COEF_MIN, 16'hFFFF);
      queue_item(FUNC_MERGE, COEF_MAX, 16'hFFFF);
      queue_item(FUNC_LOAD_FIRST, 32'sd1, 16'd10);
      queue_item(FUNC_LOAD_FIRST, 32'sd2, 16'd20);
      queue_item(FUNC_LOAD_SECOND, 32'sd3, 16'd15);
      queue_item(FUNC_LOAD_SECOND, 32'sd4, 16'd20);
      queue_item(FUNC_MERGE, '0, '0);
      queue_item(FUNC_LOAD_SECOND, -32'sd3, 16'd0);
      queue_item(FUNC_MERGE, '0, '0);
      queue_item(FUNC_LOAD_FIRST, COEF_MIN, 16'd0);
      queue_item(FUNC_LOAD_FIRST, COEF_MAX, 16'hFFFF);
      queue_item(FUNC_MERGE, '0, '0);
      queue_item(FUNC_MERGE, '0, '0);
   endtask

   task automatic fill_random(input int unsigned n_items);
      int unsigned goal;
      goal = queued_count + n_items;
      while (queued_count < goal) begin
         queue_poly_pair();
      end
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
      end while (pending_items.size() != 0 || req_chan.valid || expected_terms.size() != 0);
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      first_len        = 0;
      second_len       = 0;
      load_dropped     = 1'b0;
      hold_armed       = 1'b0;
      hold_count       = 0;
      queued_count     = 0;
      error_count      = 0;
      cycle_count      = 0;
      send_idle_pct    = 17;
      rsp_idle_pct     = 66;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      queue_directed();
      fill_random(125);
      drain();

      send_idle_pct = 66;
      rsp_idle_pct  = 17;
      fill_random(125);
      drain();

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_armed    = 1'b1;
      fill_random(120);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_terms.size() == 0) begin
         $display("sparse_poly_merge_add_top_tb passed");
      end else begin
         $display("sparse_poly_merge_add_top_tb failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/spma_pkg.sv
src/spma_chan_if.sv
src/spma_front.sv
src/spma_back.sv
src/sparse_poly_merge_add_top.sv
sim/sparse_poly_merge_add_top_tb.sv
